// ----- src/kmde_pkg.sv -----
// Shared constants and types for the key matrix debounce event block.
`timescale 1ns / 1ps

package kmde_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DEBOUNCE_W  = 16;
    localparam int COLMASK_W   = 16;
    localparam int ENTRIES_W   = 7;
    localparam int ROW_W       = 2;
    localparam int LEVELS_W    = 16;
    localparam int TIME_W      = 32;
    localparam int MAP_IDX_W   = 6;
    localparam int CODE_W      = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_MS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_ENABLE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEYMAP_ENTRIES = 2'd2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd5;
    localparam logic [COLMASK_W-1:0]  COLMASK_RESET  = 16'hFFFF;
    localparam logic [ENTRIES_W-1:0]  ENTRIES_RESET  = 7'd64;

    localparam logic ACTION_SCAN      = 1'b0;
    localparam logic ACTION_MAP_WRITE = 1'b1;

    typedef enum logic [0:0] {
        JOB_MAP_WRITE = 1'b0,
        JOB_SCAN      = 1'b1
    } job_kind_t;

    typedef struct packed {
        logic [MAP_IDX_W-1:0] index;
        logic [CODE_W-1:0]    code;
    } map_wr_t;

endpackage

// ----- src/key_matrix_debounce_events_core.sv -----
// Top level of the key matrix scanner with debounce and key event output.
`timescale 1ns / 1ps

// The front end accepts row samples and keymap writes while the job queue is
// not full. A row sample of the last row that finds the bitmap stable for
// debounce_ms queues a scan job, and keymap writes queue behind it in a
// two-entry queue, so the keymap seen by a scan is the one written before it.
// The event walker takes a job only when idle, then steps through the
// ROWS*COLS key positions one per cycle, holding at a changed key while the
// result side stalls, and goes idle after the last changed key. Events leave
// in row-major order with m_last on the final one; a keymap write job is
// written to the keymap memory as it is popped.

module key_matrix_debounce_events_core #(
    parameter int ROWS         = 4,
    parameter int COLS         = 16,
    parameter int KEYMAP_DEPTH = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [kmde_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [kmde_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [kmde_pkg::ROW_W-1:0]         s_row,
    input  logic [kmde_pkg::LEVELS_W-1:0]      s_col_levels,
    input  logic [kmde_pkg::TIME_W-1:0]        s_now_ms,
    input  logic [kmde_pkg::MAP_IDX_W-1:0]     s_map_index,
    input  logic [kmde_pkg::CODE_W-1:0]        s_map_code,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [kmde_pkg::CODE_W-1:0]        m_code,
    output logic [kmde_pkg::MAP_IDX_W-1:0]     m_key_index,
    output logic                               m_pressed,
    output logic                               m_last
);

    localparam int N  = ROWS * COLS;
    localparam int QW = 1 + $bits(kmde_pkg::map_wr_t) + N;

    logic                           q_push;
    logic [QW-1:0]                  q_push_data;
    logic                           q_full;
    logic                           q_pop;
    logic                           q_valid;
    logic [QW-1:0]                  q_pop_data;
    logic [kmde_pkg::ENTRIES_W-1:0] keymap_entries;

    kmde_front #(
        .ROWS (ROWS),
        .COLS (COLS),
        .QW   (QW)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_row          (s_row),
        .s_col_levels   (s_col_levels),
        .s_now_ms       (s_now_ms),
        .s_map_index    (s_map_index),
        .s_map_code     (s_map_code),
        .q_push         (q_push),
        .q_data         (q_push_data),
        .q_full         (q_full),
        .keymap_entries (keymap_entries)
    );

    kmde_job_queue #(
        .W (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_pop_data)
    );

    kmde_back #(
        .ROWS         (ROWS),
        .COLS         (COLS),
        .KEYMAP_DEPTH (KEYMAP_DEPTH),
        .QW           (QW)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_data         (q_pop_data),
        .q_pop          (q_pop),
        .keymap_entries (keymap_entries),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_code         (m_code),
        .m_key_index    (m_key_index),
        .m_pressed      (m_pressed),
        .m_last         (m_last)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("job queue read while empty");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((N > 64) || (32'(m_key_index) < N)))
        else $error("event key index beyond matrix");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_code != '0) |->
            ((N > 64) || ((32'(m_key_index) < 32'(keymap_entries))
                          && (32'(m_key_index) < KEYMAP_DEPTH))))
        else $error("key code given for index beyond keymap");

endmodule

// ----- src/kmde_front.sv -----
// Front end: config registers, row capture, debounce timing and job issue.
`timescale 1ns / 1ps

module kmde_front #(
    parameter int ROWS = 4,
    parameter int COLS = 16,
    parameter int QW   = 79
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [kmde_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [kmde_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [kmde_pkg::ROW_W-1:0]         s_row,
    input  logic [kmde_pkg::LEVELS_W-1:0]      s_col_levels,
    input  logic [kmde_pkg::TIME_W-1:0]        s_now_ms,
    input  logic [kmde_pkg::MAP_IDX_W-1:0]     s_map_index,
    input  logic [kmde_pkg::CODE_W-1:0]        s_map_code,
    output logic                               q_push,
    output logic [QW-1:0]                      q_data,
    input  logic                               q_full,
    output logic [kmde_pkg::ENTRIES_W-1:0]     keymap_entries
);

    localparam int N  = ROWS * COLS;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [kmde_pkg::DEBOUNCE_W-1:0] debounce_reg;
    logic [kmde_pkg::COLMASK_W-1:0]  colmask_reg;
    logic [kmde_pkg::ENTRIES_W-1:0]  entries_reg;
    logic [COLS-1:0]                 raw_map_reg [ROWS];
    logic                            scan_changed_reg;
    logic [kmde_pkg::TIME_W-1:0]     stable_start_reg;

    logic                            accept;
    logic [31:0]                     row_wide;
    logic [RW-1:0]                   row_sel;
    logic                            row_ok;
    logic                            last_row;
    logic [COLS-1:0]                 bits;
    logic                            row_changed;
    logic [kmde_pkg::TIME_W-1:0]     elapsed;
    logic                            settled_time;
    logic [N-1:0]                    snap;
    kmde_pkg::map_wr_t               map_wr;
    kmde_pkg::job_kind_t             kind;
    logic                            is_scan;

    assign s_ready        = !q_full;
    assign accept         = s_valid && s_ready;
    assign keymap_entries = entries_reg;
    assign is_scan        = (s_action == kmde_pkg::ACTION_SCAN);

    assign row_wide     = 32'(s_row);
    assign row_sel      = row_wide[RW-1:0];
    assign row_ok       = row_wide < ROWS;
    assign last_row     = row_wide == 32'(ROWS - 1);
    assign bits         = ~s_col_levels[COLS-1:0] & colmask_reg[COLS-1:0];
    assign row_changed  = raw_map_reg[row_sel] != bits;
    assign elapsed      = s_now_ms - stable_start_reg;
    assign settled_time = elapsed >= {16'd0, debounce_reg};

    // bitmap as it stands once this row is stored, row-major
    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            snap[r*COLS +: COLS] = (RW'(r) == row_sel) ? bits : raw_map_reg[r];
        end
    end

    always_comb begin
        map_wr.index = s_map_index;
        map_wr.code  = s_map_code;
        kind         = is_scan ? kmde_pkg::JOB_SCAN : kmde_pkg::JOB_MAP_WRITE;
        q_data       = {kind, map_wr, snap};
        q_push       = 1'b0;
        if (accept) begin
            if (!is_scan) begin
                q_push = 1'b1;
            end else if (row_ok && last_row && !scan_changed_reg && !row_changed
                         && settled_time) begin
                q_push = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg     <= kmde_pkg::DEBOUNCE_RESET;
            colmask_reg      <= kmde_pkg::COLMASK_RESET;
            entries_reg      <= kmde_pkg::ENTRIES_RESET;
            scan_changed_reg <= 1'b0;
            stable_start_reg <= '0;
            for (int r = 0; r < ROWS; r++) begin
                raw_map_reg[r] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    kmde_pkg::CFG_DEBOUNCE_MS:    debounce_reg <= cfg_data;
                    kmde_pkg::CFG_COLUMN_ENABLE:  colmask_reg  <= cfg_data;
                    kmde_pkg::CFG_KEYMAP_ENTRIES: entries_reg  <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (accept && is_scan && row_ok) begin
                raw_map_reg[row_sel] <= bits;
                if (last_row) begin
                    if (scan_changed_reg || row_changed) begin
                        stable_start_reg <= s_now_ms;
                    end
                    scan_changed_reg <= 1'b0;
                end else if (row_changed) begin
                    scan_changed_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- src/kmde_job_queue.sv -----
// Two-entry job queue between the front end and the event walker.
`timescale 1ns / 1ps

module kmde_job_queue #(
    parameter int W = 79
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;

    assign full     = count_reg == 2'd2;
    assign valid    = count_reg != 2'd0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: ;
            endcase
        end
    end

endmodule

// ----- src/kmde_back.sv -----
// Back end: keymap memory, settled bitmap and the per-key event walker.
`timescale 1ns / 1ps

module kmde_back #(
    parameter int ROWS         = 4,
    parameter int COLS         = 16,
    parameter int KEYMAP_DEPTH = 64,
    parameter int QW           = 79
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_valid,
    input  logic [QW-1:0]                      q_data,
    output logic                               q_pop,
    input  logic [kmde_pkg::ENTRIES_W-1:0]     keymap_entries,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [kmde_pkg::CODE_W-1:0]        m_code,
    output logic [kmde_pkg::MAP_IDX_W-1:0]     m_key_index,
    output logic                               m_pressed,
    output logic                               m_last
);

    localparam int N  = ROWS * COLS;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int AW = (KEYMAP_DEPTH > 1) ? $clog2(KEYMAP_DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } walk_state_t;

    walk_state_t                 state_reg;
    logic [N-1:0]                settled_reg;
    logic [N-1:0]                diff_reg;
    logic [IW-1:0]               idx_reg;
    logic                        m_valid_reg;
    logic [kmde_pkg::MAP_IDX_W-1:0] key_index_reg;
    logic                        press_reg;
    logic                        last_reg;
    logic                        in_range_reg;
    logic [kmde_pkg::CODE_W-1:0] code_rd_reg;
    logic [kmde_pkg::CODE_W-1:0] key_table_mem [KEYMAP_DEPTH];

    kmde_pkg::job_kind_t         job_kind;
    kmde_pkg::map_wr_t           job_map;
    logic [N-1:0]                job_snap;
    logic [31:0]                 map_wide;
    logic                        mem_we;
    logic [31:0]                 idx_wide;
    logic                        out_free;
    logic                        bit_set;
    logic [N-1:0]                diff_clear;
    logic                        out_load;
    logic                        in_range;

    assign job_kind = kmde_pkg::job_kind_t'(q_data[QW-1]);
    assign job_map  = q_data[N +: $bits(kmde_pkg::map_wr_t)];
    assign job_snap = q_data[N-1:0];
    assign map_wide = 32'(job_map.index);

    assign q_pop  = (state_reg == ST_IDLE) && q_valid;
    assign mem_we = q_pop && (job_kind == kmde_pkg::JOB_MAP_WRITE)
                    && (map_wide < KEYMAP_DEPTH);

    assign idx_wide   = 32'(idx_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign bit_set    = diff_reg[idx_reg];
    assign diff_clear = diff_reg & ~(N'(1) << idx_reg);
    assign out_load   = (state_reg == ST_WALK) && bit_set && out_free;
    assign in_range   = (idx_wide < 32'(keymap_entries)) && (idx_wide < KEYMAP_DEPTH);

    assign m_valid     = m_valid_reg;
    assign m_code      = in_range_reg ? code_rd_reg : '0;
    assign m_key_index = key_index_reg;
    assign m_pressed   = press_reg;
    assign m_last      = last_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_table_mem[map_wide[AW-1:0]] <= job_map.code;
        end
        if (out_load) begin
            code_rd_reg <= key_table_mem[idx_wide[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            key_index_reg <= idx_wide[kmde_pkg::MAP_IDX_W-1:0];
            press_reg     <= settled_reg[idx_reg];
            last_reg      <= diff_clear == '0;
            in_range_reg  <= in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            settled_reg <= '0;
            diff_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop && job_kind == kmde_pkg::JOB_SCAN) begin
                        diff_reg    <= job_snap ^ settled_reg;
                        settled_reg <= job_snap;
                        idx_reg     <= '0;
                        state_reg   <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (diff_reg == '0) begin
                        state_reg <= ST_IDLE;
                    end else if (!bit_set) begin
                        idx_reg <= idx_reg + 1'b1;
                    end else if (out_free) begin
                        // advance once the output register is free; else hold the position
                        diff_reg <= diff_clear;
                        idx_reg  <= idx_reg + 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
